@@ hw/rtl/wbsb_pkg.sv @@
package wbsb_pkg;

  localparam int DISPLAY_WIDTH  = 256;
  localparam int DISPLAY_HEIGHT = 128;
  localparam logic [15:0] TRANSPARENT_COLOR = 16'hF81F;

  localparam int COORD_W = 12;
  localparam int LEN_W   = 7;
  localparam int COLOR_W = 16;
  // Signed display positions: a 15-bit window origin plus a 12-bit cursor offset.
  localparam int POS_W   = 17;

  localparam logic signed [POS_W-1:0] DISPLAY_RIGHT  = POS_W'(DISPLAY_WIDTH);
  localparam logic signed [POS_W-1:0] DISPLAY_BOTTOM = POS_W'(DISPLAY_HEIGHT);

  localparam int JOB_DEPTH  = 2;
  localparam int SPAN_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_WINDOW_LEFT   = 3'd0,
    REG_WINDOW_TOP    = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_PALETTE_0     = 3'd4,
    REG_PALETTE_1     = 3'd5,
    REG_PALETTE_2     = 3'd6,
    REG_PALETTE_3     = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_RUN  = 1'b0,
    CMD_WORD = 1'b1
  } command_t;

  typedef struct packed {
    logic              is_word;
    logic [1:0]        run_index;
    logic [LEN_W-1:0]  run_count;
    logic [15:0]       pixels;
  } job_t;

  typedef struct packed {
    logic [14:0]                left;
    logic [14:0]                top;
    logic [COORD_W-1:0]         width;
    logic [COORD_W-1:0]         height;
    logic [3:0][COLOR_W-1:0]    palette;
  } window_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   length;
    logic [COLOR_W-1:0] color;
    logic               last;
  } span_t;

endpackage

@@ hw/rtl/wbsb_front.sv @@
module wbsb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [15:0]       data_word,
  output logic              job_valid,
  output wbsb_pkg::job_t    job,
  input  logic              job_ready
);

  localparam int PTR_W = $clog2(wbsb_pkg::JOB_DEPTH);
  localparam int CNT_W = $clog2(wbsb_pkg::JOB_DEPTH + 1);

  wbsb_pkg::job_t   entries [wbsb_pkg::JOB_DEPTH];
  wbsb_pkg::job_t   decoded;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // A run byte carries its palette index in the top two bits and its length
  // minus one in the low six bits.
  always_comb begin
    decoded.is_word   = (wbsb_pkg::command_t'(command) == wbsb_pkg::CMD_WORD);
    decoded.run_index = data_word[7:6];
    decoded.run_count = {1'b0, data_word[5:0]} + wbsb_pkg::LEN_W'(1);
    decoded.pixels    = data_word;
  end

  assign full      = (count == CNT_W'(wbsb_pkg::JOB_DEPTH));
  assign job_valid = (count != '0);
  assign job       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= decoded;
    end
  end

endmodule

@@ hw/rtl/wbsb_back.sv @@
module wbsb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  wbsb_pkg::window_cfg_t cfg,
  input  logic                  cursor_clear,
  input  logic                  job_valid,
  input  wbsb_pkg::job_t        job,
  output logic                  job_ready,
  output logic                  span_valid,
  output wbsb_pkg::span_t       span,
  input  logic                  span_ready
);

  localparam int CW = wbsb_pkg::COORD_W;
  localparam int LW = wbsb_pkg::LEN_W;
  localparam int PW = wbsb_pkg::POS_W;

  // Sequencer state
  logic                         busy;
  logic                         s_word;
  logic [1:0]                   s_index;
  logic [LW-1:0]                s_rem;
  logic [15:0]                  s_pix;
  logic [2:0]                   s_left;
  logic [CW-1:0]                col;
  logic [CW-1:0]                row;

  // Piece stage
  logic                         p_valid;
  logic signed [PW-1:0]         p_x;
  logic signed [PW-1:0]         p_y;
  logic [LW-1:0]                p_n;
  logic [wbsb_pkg::COLOR_W-1:0] p_color;
  logic                         p_end;

  // Held span, waiting to learn whether it is the last of its item
  logic                         h_valid;
  logic                         h_last;
  wbsb_pkg::span_t              h_span;

  logic [CW-1:0]                width_eff;
  logic [CW-1:0]                height_eff;
  logic [LW-1:0]                cur_count;
  logic [1:0]                   cur_index;
  logic [CW:0]                  sum;
  logic                         wrap;
  logic [CW-1:0]                gap;
  logic [LW-1:0]                piece;
  logic [LW-1:0]                rem_after;
  logic                         group_done;
  logic                         item_done;
  logic [CW:0]                  row_inc;
  logic [CW-1:0]                row_wrapped;
  logic                         gen;
  logic                         load;
  logic signed [PW-1:0]         x_pos;
  logic signed [PW-1:0]         y_pos;

  logic signed [PW-1:0]         s_pos;
  logic signed [PW-1:0]         e_raw;
  logic signed [PW-1:0]         e_pos;
  logic signed [PW-1:0]         len_full;
  logic                         p_vis;
  logic                         p_take;
  logic                         p_ready;
  logic                         push_h;

  assign width_eff  = (cfg.width == '0) ? CW'(1) : cfg.width;
  assign height_eff = (cfg.height == '0) ? CW'(1) : cfg.height;

  // One piece per cycle while the piece stage can take it: the part of the current
  // pixel group that fits on the cursor's row.
  always_comb begin
    cur_count   = s_word ? LW'(1) : s_rem;
    cur_index   = s_word ? s_pix[1:0] : s_index;
    sum         = {1'b0, col} + (CW+1)'(cur_count);
    wrap        = (sum >= {1'b0, width_eff});
    gap         = width_eff - col;
    piece       = wrap ? gap[LW-1:0] : cur_count;
    rem_after   = cur_count - piece;
    group_done  = (rem_after == '0);
    item_done   = group_done && (!s_word || (s_left == '0));
    row_inc     = {1'b0, row} + (CW+1)'(1);
    row_wrapped = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[CW-1:0];
    x_pos       = {{(PW-15){cfg.left[14]}}, cfg.left} + PW'(col);
    y_pos       = {{(PW-15){cfg.top[14]}}, cfg.top} + PW'(row);
  end

  assign gen       = busy && p_ready;
  assign job_ready = !busy || (gen && item_done);
  assign load      = job_valid && job_ready;

  // Clipping of the registered piece against the display.
  always_comb begin
    s_pos    = p_x[PW-1] ? '0 : p_x;
    e_raw    = p_x + PW'(p_n);
    e_pos    = (e_raw > wbsb_pkg::DISPLAY_RIGHT) ? wbsb_pkg::DISPLAY_RIGHT : e_raw;
    len_full = e_pos - s_pos;
    p_vis    = (p_color != wbsb_pkg::TRANSPARENT_COLOR) && !p_y[PW-1]
               && (p_y < wbsb_pkg::DISPLAY_BOTTOM) && (s_pos < e_pos);
  end

  // The held span goes out once the next visible span arrives, or once the
  // item ends, in which case it carries the last flag.
  always_comb begin
    push_h = h_valid && span_ready
             && (h_last || (p_valid && (p_vis || p_end)));
    if (!p_valid) begin
      p_take = 1'b0;
    end else if (p_vis) begin
      p_take = !h_valid || push_h;
    end else if (p_end && h_valid && !h_last) begin
      p_take = push_h;
    end else begin
      p_take = 1'b1;
    end
    p_ready = !p_valid || p_take;
  end

  assign span_valid = push_h;
  always_comb begin
    span      = h_span;
    span.last = h_last || !p_vis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      p_valid <= 1'b0;
      h_valid <= 1'b0;
      h_last  <= 1'b0;
      col     <= '0;
      row     <= '0;
    end else begin
      if (cursor_clear) begin
        col <= '0;
        row <= '0;
      end else if (gen) begin
        col <= wrap ? '0 : sum[CW-1:0];
        row <= wrap ? row_wrapped : row;
      end

      if (load) begin
        busy <= 1'b1;
      end else if (gen && item_done) begin
        busy <= 1'b0;
      end

      if (gen) begin
        p_valid <= 1'b1;
      end else if (p_take) begin
        p_valid <= 1'b0;
      end

      if (p_take && p_vis) begin
        h_valid <= 1'b1;
        h_last  <= p_end;
      end else if (push_h) begin
        h_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_word  <= job.is_word;
      s_index <= job.run_index;
      s_rem   <= job.run_count;
      s_pix   <= job.pixels;
      s_left  <= 3'd7;
    end else if (gen) begin
      if (!group_done) begin
        s_rem <= rem_after;
      end else if (s_word) begin
        s_pix  <= {2'b00, s_pix[15:2]};
        s_left <= s_left - 3'd1;
      end
    end

    if (gen) begin
      p_x     <= x_pos;
      p_y     <= y_pos;
      p_n     <= piece;
      p_color <= cfg.palette[cur_index];
      p_end   <= item_done;
    end

    if (p_take && p_vis) begin
      h_span.x      <= s_pos[CW-1:0];
      h_span.y      <= p_y[CW-1:0];
      h_span.length <= len_full[LW-1:0];
      h_span.color  <= p_color;
      h_span.last   <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/wbsb_span_queue.sv @@
module wbsb_span_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  wbsb_pkg::span_t wr_data,
  output logic            wr_ready,
  input  logic            pop,
  output logic            empty,
  output wbsb_pkg::span_t rd_data
);

  localparam int PTR_W = $clog2(wbsb_pkg::SPAN_DEPTH);
  localparam int CNT_W = $clog2(wbsb_pkg::SPAN_DEPTH + 1);

  wbsb_pkg::span_t  entries [wbsb_pkg::SPAN_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign wr_ready = (count != CNT_W'(wbsb_pkg::SPAN_DEPTH));
  assign empty    = (count == '0);
  assign rd_data  = entries[rd_ptr];
  assign do_push  = wr_valid && wr_ready;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/windowed_bitmap_span_blitter.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------------
// input    | push / full                | command, data_word
// result   | empty / pop                | span_x, span_y, span_length, span_color,
//          |                            | last_span
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An item is split into row pieces: a run yields one piece for each window row it paints
// into, a palette word yields eight pieces, one per pixel. The back-end sequencer walks
// the cursor one piece per cycle while its piece stage is not stalled. A result passes
// through the piece register and the held-span register into the span queue.
// rst is synchronous and clears the cursor, queues and palette; the window resets to 1x1 at 0,0.
// Input and result sides stall independently through the job and span queues.
module windowed_bitmap_span_blitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [15:0] data_word,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] span_x,
  output logic [11:0] span_y,
  output logic [6:0]  span_length,
  output logic [15:0] span_color,
  output logic        last_span,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  wbsb_pkg::window_cfg_t cfg;
  wbsb_pkg::job_t        job;
  wbsb_pkg::span_t       span_in;
  wbsb_pkg::span_t       span_out;
  logic                  job_valid;
  logic                  job_ready;
  logic                  span_valid;
  logic                  span_ready;
  logic                  cfg_write;
  logic                  cursor_clear;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Any write to the window geometry restarts the cursor at the top left.
  always_comb begin
    case (wbsb_pkg::cfg_reg_t'(cfg_index))
      wbsb_pkg::REG_WINDOW_LEFT,
      wbsb_pkg::REG_WINDOW_TOP,
      wbsb_pkg::REG_WINDOW_WIDTH,
      wbsb_pkg::REG_WINDOW_HEIGHT: cursor_clear = cfg_write;
      default:                     cursor_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left    <= '0;
      cfg.top     <= '0;
      cfg.width   <= 12'd1;
      cfg.height  <= 12'd1;
      cfg.palette <= '0;
    end else if (cfg_write) begin
      case (wbsb_pkg::cfg_reg_t'(cfg_index))
        wbsb_pkg::REG_WINDOW_LEFT:   cfg.left       <= cfg_data[14:0];
        wbsb_pkg::REG_WINDOW_TOP:    cfg.top        <= cfg_data[14:0];
        wbsb_pkg::REG_WINDOW_WIDTH:  cfg.width      <= cfg_data[11:0];
        wbsb_pkg::REG_WINDOW_HEIGHT: cfg.height     <= cfg_data[11:0];
        wbsb_pkg::REG_PALETTE_0:     cfg.palette[0] <= cfg_data;
        wbsb_pkg::REG_PALETTE_1:     cfg.palette[1] <= cfg_data;
        wbsb_pkg::REG_PALETTE_2:     cfg.palette[2] <= cfg_data;
        wbsb_pkg::REG_PALETTE_3:     cfg.palette[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wbsb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .data_word (data_word),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  wbsb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cursor_clear (cursor_clear),
    .job_valid    (job_valid),
    .job          (job),
    .job_ready    (job_ready),
    .span_valid   (span_valid),
    .span         (span_in),
    .span_ready   (span_ready)
  );

  wbsb_span_queue u_span_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (span_valid),
    .wr_data  (span_in),
    .wr_ready (span_ready),
    .pop      (pop),
    .empty    (empty),
    .rd_data  (span_out)
  );

  assign span_x      = span_out.x;
  assign span_y      = span_out.y;
  assign span_length = span_out.length;
  assign span_color  = span_out.color;
  assign last_span   = span_out.last;

endmodule

@@ dv/windowed_bitmap_span_blitter_test.sv @@
`timescale 1ns / 100ps

module windowed_bitmap_span_blitter_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        command = 1'b0;
  logic [15:0] data_word = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [11:0] span_x;
  logic [11:0] span_y;
  logic [6:0]  span_length;
  logic [15:0] span_color;
  logic        last_span;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow of the window registers and the fill cursor.
  int          win_left, win_top, win_width, win_height;
  logic [15:0] pal [4];
  int          cur_col, cur_row;
  int          item_spans;

  wbsb_pkg::span_t pending_spans [$];
  int              span_mismatches = 0;
  bit              idle_on = 1'b1;

  windowed_bitmap_span_blitter dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .data_word  (data_word),
    .empty      (empty),
    .pop        (pop),
    .span_x     (span_x),
    .span_y     (span_y),
    .span_length(span_length),
    .span_color (span_color),
    .last_span  (last_span),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Clips one row piece to the display and queues it unless it is invisible.
  task automatic emit_piece(input logic [15:0] color, input int x, input int y, input int n);
    int              s, e;
    wbsb_pkg::span_t sp;
    if (color == wbsb_pkg::TRANSPARENT_COLOR || n == 0) return;
    if (y < 0 || y >= wbsb_pkg::DISPLAY_HEIGHT) return;
    s = (x < 0) ? 0 : x;
    e = x + n;
    if (e > wbsb_pkg::DISPLAY_WIDTH) e = wbsb_pkg::DISPLAY_WIDTH;
    if (s >= e) return;
    sp.x      = 12'(s);
    sp.y      = 12'(y);
    sp.length = 7'(e - s);
    sp.color  = color;
    sp.last   = 1'b0;
    pending_spans.push_back(sp);
    item_spans++;
  endtask

  task automatic paint_pixels(input logic [15:0] color, input int count);
    int w, h, piece;
    w = (win_width == 0) ? 1 : win_width;
    h = (win_height == 0) ? 1 : win_height;
    while (cur_col + count >= w) begin
      piece = w - cur_col;
      emit_piece(color, win_left + cur_col, win_top + cur_row, piece);
      count -= piece;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
      cur_col = 0;
    end
    emit_piece(color, win_left + cur_col, win_top + cur_row, count);
    cur_col += count;
  endtask

  task automatic paint_item(input wbsb_pkg::command_t cmd, input logic [15:0] word);
    item_spans = 0;
    if (cmd == wbsb_pkg::CMD_RUN) begin
      paint_pixels(pal[word[7:6]], int'(word[5:0]) + 1);
    end else begin
      for (int j = 0; j < 8; j++) paint_pixels(pal[word[2*j +: 2]], 1);
    end
    if (item_spans > 0) pending_spans[pending_spans.size() - 1].last = 1'b1;
  endtask

  task automatic apply_reg(input wbsb_pkg::cfg_reg_t idx, input logic [15:0] data);
    case (idx)
      wbsb_pkg::REG_WINDOW_LEFT:   win_left = $signed(data[14:0]);
      wbsb_pkg::REG_WINDOW_TOP:    win_top = $signed(data[14:0]);
      wbsb_pkg::REG_WINDOW_WIDTH:  win_width = data[11:0];
      wbsb_pkg::REG_WINDOW_HEIGHT: win_height = data[11:0];
      default:                     pal[int'(idx) - int'(wbsb_pkg::REG_PALETTE_0)] = data;
    endcase
    if (idx < wbsb_pkg::REG_PALETTE_0) begin
      cur_col = 0;
      cur_row = 0;
    end
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input wbsb_pkg::cfg_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Stops input, lets every expected span drain, then waits out items that paint nothing.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_window(input int left, input int top, input int width, input int height);
    wait_idle();
    write_reg(wbsb_pkg::REG_WINDOW_LEFT, 16'(left));
    write_reg(wbsb_pkg::REG_WINDOW_TOP, 16'(top));
    write_reg(wbsb_pkg::REG_WINDOW_WIDTH, 16'(width));
    write_reg(wbsb_pkg::REG_WINDOW_HEIGHT, 16'(height));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_palette(input logic [15:0] c0, input logic [15:0] c1,
                             input logic [15:0] c2, input logic [15:0] c3);
    wait_idle();
    write_reg(wbsb_pkg::REG_PALETTE_0, c0);
    write_reg(wbsb_pkg::REG_PALETTE_1, c1);
    write_reg(wbsb_pkg::REG_PALETTE_2, c2);
    write_reg(wbsb_pkg::REG_PALETTE_3, c3);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Push stays high after the transaction so back-to-back items need no extra edge.
  task automatic send_item(input wbsb_pkg::command_t cmd, input logic [15:0] word);
    while (idle_on && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    command   <= cmd;
    data_word <= word;
    @(posedge clk);
    while (full) @(posedge clk);
    paint_item(cmd, word);
  endtask

  task automatic send_random_item();
    if ($urandom_range(1)) send_item(wbsb_pkg::CMD_WORD, 16'($urandom));
    else send_item(wbsb_pkg::CMD_RUN, 16'($urandom));
  endtask

  function automatic logic [15:0] random_color();
    case ($urandom_range(7))
      0:       return wbsb_pkg::TRANSPARENT_COLOR;
      1:       return 16'h0000;
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_span();
    wbsb_pkg::span_t got, want;
    got = {span_x, span_y, span_length, span_color, last_span};
    if (pending_spans.size() == 0) begin
      span_mismatches++;
      if (span_mismatches <= 10)
        $display("unexpected span: x=%0d y=%0d len=%0d color=%h last=%b",
                 got.x, got.y, got.length, got.color, got.last);
      return;
    end
    want = pending_spans.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.length !== want.length ||
        got.color !== want.color || got.last !== want.last) begin
      span_mismatches++;
      if (span_mismatches <= 10)
        $display({"span mismatch: expected x=%0d y=%0d len=%0d color=%h last=%b,",
                  " got x=%0d y=%0d len=%0d color=%h last=%b"},
                 want.x, want.y, want.length, want.color, want.last,
                 got.x, got.y, got.length, got.color, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_span();
      pop <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  // Reset window is 1x1 at the origin with all colors 0: every pixel is its own span.
  task automatic test_reset_state();
    send_item(wbsb_pkg::CMD_RUN, 16'hFF3F);
    send_item(wbsb_pkg::CMD_RUN, 16'h0000);
    send_item(wbsb_pkg::CMD_WORD, 16'hFFFF);
  endtask

  task automatic test_edge_clipping();
    set_window(250, 126, 20, 3);
    set_palette(16'h0000, wbsb_pkg::TRANSPARENT_COLOR, 16'hFFFF, 16'h1234);
    // A run that ends exactly at the window's right edge, clipped by the display.
    send_item(wbsb_pkg::CMD_RUN, 16'h0093);
    // Transparent run: nothing is emitted but the cursor moves.
    send_item(wbsb_pkg::CMD_RUN, 16'h0045);
    // Long run that wraps through an off-screen row and back to the top.
    send_item(wbsb_pkg::CMD_RUN, 16'h00FF);
    send_item(wbsb_pkg::CMD_WORD, 16'h1B1B);
    send_item(wbsb_pkg::CMD_WORD, 16'h5555);
    set_window(-10, -1, 12, 2);
    send_item(wbsb_pkg::CMD_RUN, 16'h000B);
    send_item(wbsb_pkg::CMD_RUN, 16'hAACB);
    send_item(wbsb_pkg::CMD_WORD, 16'hAAAA);
    send_item(wbsb_pkg::CMD_WORD, 16'h0000);
  endtask

  task automatic test_extreme_windows();
    set_window(-16384, -16384, 4095, 4095);
    send_item(wbsb_pkg::CMD_RUN, 16'h00FF);
    send_item(wbsb_pkg::CMD_WORD, 16'hE4E4);
    set_window(16383, 16383, 1, 1);
    send_item(wbsb_pkg::CMD_RUN, 16'h00FF);
    send_item(wbsb_pkg::CMD_WORD, 16'h27C9);
    set_window(0, 0, 4095, 1);
    send_item(wbsb_pkg::CMD_RUN, 16'h00FF);
    send_item(wbsb_pkg::CMD_WORD, 16'h9C63);
    set_window(-16384, 0, 4095, 4095);
    send_item(wbsb_pkg::CMD_RUN, 16'h00BF);
    send_item(wbsb_pkg::CMD_WORD, 16'hFFFF);
    set_window(0, 127, 4095, 4095);
    send_item(wbsb_pkg::CMD_RUN, 16'h007F);
    send_item(wbsb_pkg::CMD_RUN, 16'h0000);
  endtask

  task automatic random_window();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      set_window($urandom_range(1) ? -16384 : 16383, $urandom_range(1) ? -16384 : 16383,
                 $urandom_range(1) ? 1 : 4095, $urandom_range(1) ? 1 : 4095);
    end else if (pick == 1) begin
      set_window($urandom_range(600) - 300, $urandom_range(300) - 150,
                 $urandom_range(1, 400), $urandom_range(1, 200));
    end else begin
      set_window($urandom_range(300) - 40, $urandom_range(140) - 8,
                 $urandom_range(1, 80), $urandom_range(1, 12));
    end
  endtask

  // Several window settings; one phase runs with no idling on either side, and
  // some phases change the palette halfway, which must keep the cursor.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 9; phase++) begin
      idle_on = (phase != 4);
      random_window();
      set_palette(random_color(), random_color(), random_color(), random_color());
      for (int i = 0; i < 22; i++) begin
        if (i == 11 && phase % 2 == 1)
          set_palette(random_color(), random_color(), random_color(), random_color());
        send_random_item();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    win_left   = 0;
    win_top    = 0;
    win_width  = 1;
    win_height = 1;
    for (int i = 0; i < 4; i++) pal[i] = '0;
    cur_col = 0;
    cur_row = 0;
    @(posedge clk);
    test_reset_state();
    test_edge_clipping();
    test_extreme_windows();
    test_random_traffic();
    wait_idle();
    if (span_mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
